// File: sv/bpa_pkg.sv
package bpa_pkg;

    localparam int PAGES     = 4096;
    localparam int TOP_ORDER = 10;
    localparam int AW        = 12;              // page index width
    localparam int LW        = AW + 1;          // link width, holds NIL
    localparam int MW        = 5;               // page mark width
    localparam int OW        = 4;               // order width
    localparam int NORD      = TOP_ORDER + 1;
    localparam int RW        = 16;              // request width

    localparam logic [LW-1:0] NIL = LW'(PAGES);

    localparam logic [MW-1:0] M_NONE          = MW'(0);
    localparam logic [MW-1:0] M_FREE_PART     = MW'(1);
    localparam logic [MW-1:0] M_FREE_HEAD0    = MW'(3);
    localparam logic [MW-1:0] M_ALLOC_HEAD0   = MW'(4 + TOP_ORDER);
    localparam logic [MW-1:0] M_ALLOC_HEADTOP = MW'(4 + 2 * TOP_ORDER);

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_INIT  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_ZERO    = 3'd1,
        ST_BIG     = 3'd2,
        ST_OOM     = 3'd3,
        ST_BADFREE = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_A_CHK, S_A_FIND, S_A_RM, S_SPLIT, S_A_MARK,
        S_INS_A, S_INS_B, S_F_CHK, S_F_MARK, S_M_CHK, S_M_TEST, S_F_FIN,
        S_BUILD, S_DONE
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_CLEAR, OP_A_CHK, OP_A_FIND, OP_A_RM, OP_SPLIT,
        OP_A_MARK, OP_INS_A, OP_INS_B, OP_F_CHK, OP_F_MARK, OP_M_CHK,
        OP_M_TEST, OP_F_FIN, OP_BUILD, OP_EMIT
    } t_op;

    typedef struct packed {
        logic sweep_last;
        logic req_bad;
        logic found;
        logic split_more;
        logic range_bad;
        logic alloc_head;
        logic merge_ok;
        logic bud_free;
        logic build_more;
        logic out_free;
    } t_sts;

endpackage

// File: sv/bpa_ctrl.sv
module bpa_ctrl
    import bpa_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_cmd i_cmd,
    input  t_sts i_sts,
    output logic o_ready,
    output t_op  o_op
);

    t_state r_state, n_state;
    t_cmd   r_kind, n_kind;
    logic   r_boot, n_boot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_kind  <= CMD_NOP;
            r_boot  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
            r_boot  <= n_boot;
        end
    end

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        n_boot  = r_boot;
        unique case (r_state)
            S_CLEAR: begin
                if (i_sts.sweep_last) begin
                    n_boot  = 1'b0;
                    n_state = r_boot ? S_IDLE : S_BUILD;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_kind = i_cmd;
                    unique case (i_cmd)
                        CMD_ALLOC: n_state = S_A_CHK;
                        CMD_FREE:  n_state = S_F_CHK;
                        CMD_INIT:  n_state = S_CLEAR;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_A_CHK:  n_state = i_sts.req_bad ? S_DONE : S_A_FIND;
            S_A_FIND: n_state = i_sts.found ? S_A_RM : S_DONE;
            S_A_RM:   n_state = S_SPLIT;
            S_SPLIT:  n_state = i_sts.split_more ? S_INS_A : S_A_MARK;
            S_A_MARK: n_state = S_DONE;
            S_INS_A:  n_state = S_INS_B;
            S_INS_B: begin
                unique case (r_kind)
                    CMD_ALLOC: n_state = S_SPLIT;
                    CMD_INIT:  n_state = S_BUILD;
                    default:   n_state = S_DONE;
                endcase
            end
            S_F_CHK:  n_state = i_sts.range_bad ? S_DONE : S_F_MARK;
            S_F_MARK: n_state = i_sts.alloc_head ? S_M_CHK : S_DONE;
            S_M_CHK:  n_state = i_sts.merge_ok ? S_M_TEST : S_F_FIN;
            S_M_TEST: n_state = i_sts.bud_free ? S_M_CHK : S_F_FIN;
            S_F_FIN:  n_state = S_INS_A;
            S_BUILD:  n_state = i_sts.build_more ? S_INS_A : S_DONE;
            S_DONE:   n_state = i_sts.out_free ? S_IDLE : S_DONE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_op    = OP_NONE;
        unique case (r_state)
            S_CLEAR: o_op = OP_CLEAR;
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) o_op = OP_LOAD;
            end
            S_A_CHK:  o_op = OP_A_CHK;
            S_A_FIND: o_op = OP_A_FIND;
            S_A_RM:   o_op = OP_A_RM;
            S_SPLIT:  o_op = OP_SPLIT;
            S_A_MARK: o_op = OP_A_MARK;
            S_INS_A:  o_op = OP_INS_A;
            S_INS_B:  o_op = OP_INS_B;
            S_F_CHK:  o_op = OP_F_CHK;
            S_F_MARK: o_op = OP_F_MARK;
            S_M_CHK:  o_op = OP_M_CHK;
            S_M_TEST: o_op = OP_M_TEST;
            S_F_FIN:  o_op = OP_F_FIN;
            S_BUILD:  o_op = OP_BUILD;
            S_DONE:   o_op = i_sts.out_free ? OP_EMIT : OP_NONE;
            default:  o_op = OP_NONE;
        endcase
    end

endmodule

// File: sv/bpa_dpath.sv
module bpa_dpath
    import bpa_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_op           i_op,
    input  logic          i_cfg_we,
    input  logic [12:0]   i_cfg_wdata,
    input  logic [RW-1:0] i_req,
    input  logic [AW-1:0] i_pidx,
    input  logic          i_out_ready,
    output t_sts          o_sts,
    output logic          o_out_valid,
    output logic [2:0]    o_status,
    output logic [AW-1:0] o_bidx,
    output logic [OW-1:0] o_bord
);

    // free-list state
    logic [MW-1:0] mark_mem [PAGES];
    logic [LW-1:0] next_mem [PAGES];
    logic [LW-1:0] prev_mem [PAGES];
    logic [LW-1:0] r_head [NORD];

    logic [12:0]   r_total_pages;
    logic [RW-1:0] r_req;
    logic [AW-1:0] r_pidx;
    logic [AW-1:0] r_cnt;
    logic [LW-1:0] r_idx;
    logic [OW-1:0] r_cur, r_k;
    logic [AW-1:0] r_bud, r_ins_idx;
    logic [OW-1:0] r_ins_ord;
    logic [LW-1:0] r_old;
    t_status       r_status;
    logic [AW-1:0] r_bidx;
    logic [OW-1:0] r_bord;
    logic          r_o_valid;
    logic [2:0]    r_o_status;
    logic [AW-1:0] r_o_bidx;
    logic [OW-1:0] r_o_bord;
    logic [MW-1:0] r_rd_mark;
    logic [LW-1:0] r_rd_next, r_rd_prev;

    logic [12:0]   managed;
    logic [AW-1:0] bud, loser;
    logic [RW-1:0] req_m1;
    logic [OW-1:0] k_calc, sel, bsel;
    logic          found;
    logic [13:0]   bsz;

    logic          mk_we, nx_we, pv_we;
    logic [AW-1:0] mk_wa, nx_wa, pv_wa, mk_ra, nx_ra;
    logic [MW-1:0] mk_wd;
    logic [LW-1:0] nx_wd, pv_wd;

    assign managed = (r_total_pages > 13'(PAGES)) ? 13'(PAGES) : r_total_pages;
    assign bud     = r_idx[AW-1:0] ^ (AW'(1) << r_cur);
    assign loser   = (r_bud > r_idx[AW-1:0]) ? r_bud : r_idx[AW-1:0];
    assign req_m1  = r_req - RW'(1);

    always_comb begin
        k_calc = '0;
        for (int i = 0; i < NORD; i++) begin
            if (req_m1[i]) k_calc = OW'(i + 1);
        end
    end

    // smallest non-empty list at or above the wanted order
    always_comb begin
        sel   = '0;
        found = 1'b0;
        for (int o = TOP_ORDER; o >= 0; o--) begin
            if (OW'(o) >= r_k && r_head[o] < NIL) begin
                sel   = OW'(o);
                found = 1'b1;
            end
        end
    end

    // largest aligned block that fits at r_idx
    always_comb begin
        logic [13:0] sz;
        bsel = '0;
        for (int o = 1; o < NORD; o++) begin
            sz = 14'(1) << o;
            if (((14'(r_idx) & (sz - 14'd1)) == 14'd0) && (14'(r_idx) + sz <= 14'(managed)))
                bsel = OW'(o);
        end
    end
    assign bsz = 14'(1) << bsel;

    always_comb begin
        o_sts.sweep_last = (r_cnt == '1);
        o_sts.req_bad    = (r_req == '0) || (r_req > (RW'(1) << TOP_ORDER));
        o_sts.found      = found;
        o_sts.split_more = (r_cur > r_k);
        o_sts.range_bad  = (13'(r_pidx) >= managed);
        o_sts.alloc_head = (r_rd_mark >= M_ALLOC_HEAD0) && (r_rd_mark <= M_ALLOC_HEADTOP);
        o_sts.merge_ok   = (r_cur < OW'(TOP_ORDER)) && (13'(bud) < managed);
        o_sts.bud_free   = (r_rd_mark == M_FREE_HEAD0 + MW'(r_cur));
        o_sts.build_more = (r_idx < managed);
        o_sts.out_free   = !r_o_valid || i_out_ready;
    end

    // memory ports
    always_comb begin
        mk_we = 1'b0; mk_wa = r_ins_idx; mk_wd = M_FREE_HEAD0 + MW'(r_ins_ord);
        nx_we = 1'b0; nx_wa = r_ins_idx; nx_wd = r_head[r_ins_ord];
        pv_we = 1'b0; pv_wa = r_ins_idx; pv_wd = NIL;
        mk_ra = bud;
        nx_ra = bud;
        case (i_op)
            OP_CLEAR: begin
                mk_we = 1'b1; mk_wa = r_cnt; mk_wd = M_NONE;
            end
            OP_A_FIND: nx_ra = r_head[sel][AW-1:0];
            OP_A_RM: begin
                pv_we = (r_rd_next < NIL); pv_wa = r_rd_next[AW-1:0]; pv_wd = NIL;
            end
            OP_A_MARK: begin
                mk_we = 1'b1; mk_wa = r_idx[AW-1:0]; mk_wd = M_ALLOC_HEAD0 + MW'(r_k);
            end
            OP_INS_A: begin
                mk_we = 1'b1; nx_we = 1'b1; pv_we = 1'b1;
            end
            OP_INS_B: begin
                pv_we = (r_old < NIL); pv_wa = r_old[AW-1:0]; pv_wd = LW'(r_ins_idx);
            end
            OP_F_CHK: mk_ra = r_pidx;
            OP_M_TEST: begin
                if (o_sts.bud_free) begin
                    mk_we = 1'b1; mk_wa = loser; mk_wd = M_FREE_PART;
                    nx_we = (r_rd_prev < NIL); nx_wa = r_rd_prev[AW-1:0]; nx_wd = r_rd_next;
                    pv_we = (r_rd_next < NIL); pv_wa = r_rd_next[AW-1:0]; pv_wd = r_rd_prev;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mk_we) mark_mem[mk_wa] <= mk_wd;
        r_rd_mark <= mark_mem[mk_ra];
    end

    always_ff @(posedge i_clk) begin
        if (nx_we) next_mem[nx_wa] <= nx_wd;
        r_rd_next <= next_mem[nx_ra];
    end

    always_ff @(posedge i_clk) begin
        if (pv_we) prev_mem[pv_wa] <= pv_wd;
        r_rd_prev <= prev_mem[bud];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_pages <= 13'(PAGES);
            r_cnt         <= '0;
            r_o_valid     <= 1'b0;
            for (int o = 0; o < NORD; o++) r_head[o] <= NIL;
        end else begin
            if (i_cfg_we) r_total_pages <= i_cfg_wdata;
            if (i_op == OP_CLEAR) begin
                r_cnt <= r_cnt + AW'(1);
                for (int o = 0; o < NORD; o++) r_head[o] <= NIL;
            end
            if (i_op == OP_A_RM) r_head[r_cur] <= r_rd_next;
            if (i_op == OP_INS_A) r_head[r_ins_ord] <= LW'(r_ins_idx);
            if (i_op == OP_M_TEST && o_sts.bud_free && !(r_rd_prev < NIL))
                r_head[r_cur] <= r_rd_next;
            if (i_op == OP_EMIT) r_o_valid <= 1'b1;
            else if (i_out_ready) r_o_valid <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LOAD: begin
                r_req <= i_req; r_pidx <= i_pidx;
                r_status <= ST_OK; r_bidx <= '0; r_bord <= '0;
            end
            OP_CLEAR: r_idx <= '0;
            OP_A_CHK: begin
                r_k <= k_calc;
                if (r_req == '0) r_status <= ST_ZERO;
                else if (o_sts.req_bad) r_status <= ST_BIG;
            end
            OP_A_FIND: begin
                if (found) begin
                    r_cur <= sel;
                    r_idx <= r_head[sel];
                end else begin
                    r_status <= ST_OOM;
                    r_bord   <= r_k;
                end
            end
            OP_SPLIT: begin
                if (o_sts.split_more) begin
                    r_cur     <= r_cur - OW'(1);
                    r_ins_idx <= r_idx[AW-1:0] + (AW'(1) << (r_cur - OW'(1)));
                    r_ins_ord <= r_cur - OW'(1);
                end
            end
            OP_A_MARK: begin
                r_bidx <= r_idx[AW-1:0];
                r_bord <= r_k;
            end
            OP_INS_A: r_old <= r_head[r_ins_ord];
            OP_F_CHK: begin
                if (o_sts.range_bad) begin
                    r_status <= ST_BADFREE;
                    r_bidx   <= r_pidx;
                end
            end
            OP_F_MARK: begin
                if (o_sts.alloc_head) begin
                    r_cur <= OW'(r_rd_mark - M_ALLOC_HEAD0);
                    r_idx <= LW'(r_pidx);
                end else begin
                    r_status <= ST_BADFREE;
                    r_bidx   <= r_pidx;
                end
            end
            OP_M_CHK: r_bud <= bud;
            OP_M_TEST: begin
                if (o_sts.bud_free) begin
                    r_cur <= r_cur + OW'(1);
                    if (r_bud < r_idx[AW-1:0]) r_idx <= LW'(r_bud);
                end
            end
            OP_F_FIN: begin
                r_ins_idx <= r_idx[AW-1:0];
                r_ins_ord <= r_cur;
                r_bidx    <= r_idx[AW-1:0];
                r_bord    <= r_cur;
            end
            OP_BUILD: begin
                if (o_sts.build_more) begin
                    r_ins_idx <= r_idx[AW-1:0];
                    r_ins_ord <= bsel;
                    r_idx     <= LW'(14'(r_idx) + bsz);
                end
            end
            OP_EMIT: begin
                r_o_status <= r_status;
                r_o_bidx   <= r_bidx;
                r_o_bord   <= r_bord;
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_o_valid;
    assign o_status    = r_o_status;
    assign o_bidx      = r_o_bidx;
    assign o_bord      = r_o_bord;

endmodule

// File: sv/buddy_page_allocator_unit.sv
// Binary buddy page allocator over 4096 pages, orders 0 to 10. One command per input
// beat (allocate, free, initialize, no-op), one result beat per command. A controller
// FSM sequences a datapath holding three page tables (mark, next, prev link), each with
// one write port and a registered read port. Allocate pops a free block and splits it
// down level by level; free merges the block with free buddies level by level.
// Initialize sweeps the mark table clear, then inserts each initial free block. After
// reset the same clearing sweep runs before the first command is accepted; write
// total_pages only while no command is in flight. The input is ready again as soon as
// a result sits in the output register.
module buddy_page_allocator_unit
    import bpa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [12:0] i_cfg_wdata,     // total_pages
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,    // [15:0] request_pages, [27:16] page_index
    input  logic [1:0]  s_axis_tuser,    // [1:0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,    // [11:0] block_index, [15:12] block_order
    output logic [2:0]  m_axis_tuser     // [2:0] status
);

    t_op           op;
    t_sts          sts;
    logic [AW-1:0] bidx;
    logic [OW-1:0] bord;

    bpa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_cmd   (t_cmd'(s_axis_tuser)),
        .i_sts   (sts),
        .o_ready (s_axis_tready),
        .o_op    (op)
    );

    bpa_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (op),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (s_axis_tdata[15:0]),
        .i_pidx      (s_axis_tdata[27:16]),
        .i_out_ready (m_axis_tready),
        .o_sts       (sts),
        .o_out_valid (m_axis_tvalid),
        .o_status    (m_axis_tuser),
        .o_bidx      (bidx),
        .o_bord      (bord)
    );

    assign m_axis_tdata = {bord, bidx};

endmodule
